// File: design/md5_pkg.sv
package md5_pkg;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hefcdab89;
    localparam logic [31:0] H2_INIT = 32'h98badcfe;
    localparam logic [31:0] H3_INIT = 32'h10325476;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_OFFSET  = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int QUEUE_DEPTH = 4;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_item;

    typedef struct packed {
        logic [63:0] first_half;
        logic [63:0] second_half;
    } t_digest;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        logic [4:0] s;
        begin
            case ({rnd[5:4], rnd[1:0]})
                4'b0000: s = 5'd7;
                4'b0001: s = 5'd12;
                4'b0010: s = 5'd17;
                4'b0011: s = 5'd22;
                4'b0100: s = 5'd5;
                4'b0101: s = 5'd9;
                4'b0110: s = 5'd14;
                4'b0111: s = 5'd20;
                4'b1000: s = 5'd4;
                4'b1001: s = 5'd11;
                4'b1010: s = 5'd16;
                4'b1011: s = 5'd23;
                4'b1100: s = 5'd6;
                4'b1101: s = 5'd10;
                4'b1110: s = 5'd15;
                default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    function automatic logic [3:0] word_index(input logic [5:0] rnd);
        logic [3:0] g;
        begin
            case (rnd[5:4])
                2'd0:    g = rnd[3:0];
                2'd1:    g = 4'((5 * rnd[3:0]) + 1);
                2'd2:    g = 4'((3 * rnd[3:0]) + 5);
                default: g = 4'(7 * rnd[3:0]);
            endcase
            return g;
        end
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] d;
        begin
            d = {v, v} << s;
            return d[63:32];
        end
    endfunction

endpackage

// File: design/md5_front.sv
module md5_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_has_byte,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_message,
    output logic               o_q_valid,
    input  logic               i_q_ready,
    output md5_pkg::t_item     o_q_item
);
    import md5_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr;
    logic [PTR_W:0]     r_count;
    logic               push, pop;
    t_item              in_item;

    assign in_item  = '{has_byte: i_has_byte, data_byte: i_data_byte,
                        end_of_message: i_end_of_message};
    // items with neither byte nor end mark do nothing: drop them here
    assign o_ready  = (r_count != (PTR_W+1)'(QUEUE_DEPTH));
    assign push     = i_valid && o_ready && (i_has_byte || i_end_of_message);
    assign o_q_valid = (r_count != '0);
    assign pop      = o_q_valid && i_q_ready;
    assign o_q_item = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= in_item;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + 1'b1;
            if (pop)  r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

// File: design/md5_back.sv
module md5_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  md5_pkg::t_item     i_q_item,
    output logic               o_valid,
    input  logic               i_ready,
    output md5_pkg::t_digest   o_digest
);
    import md5_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_ADD  = 4'b1000
    } t_state;

    t_state       r_state, n_state;
    logic [31:0]  r_w [16];     // block buffer, little-endian words
    logic [63:0]  r_bits;
    logic [63:0]  r_len;
    logic [31:0]  r_h [4];
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [5:0]   r_rnd;
    logic [5:0]   r_ppos;       // padding write position
    logic         r_fin;        // end mark taken, digest still to come
    logic         r_mark;       // 0x80 pad byte not yet written
    logic         r_last;       // block being built carries the length
    logic         r_out_valid;
    t_digest      r_out;

    logic [5:0]   pos;
    logic [31:0]  f, t, wg;
    logic [3:0]   g;
    logic         take, out_load;
    logic         wr_en;
    logic [5:0]   wr_idx;
    logic [7:0]   wr_byte;
    logic [7:0]   len_byte;

    assign pos      = r_bits[8:3];
    assign g        = word_index(r_rnd);
    assign wg       = r_w[g];
    assign len_byte = r_len[{r_ppos[2:0], 3'b000} +: 8];

    always_comb begin
        case (r_rnd[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        t = r_b + rotl32(r_a + f + wg + ROUND_K[r_rnd], rot_amount(r_rnd));
    end

    assign o_q_ready = (r_state == ST_IDLE);
    assign take      = i_q_valid && (r_state == ST_IDLE);
    // a new digest loads only once the previous one has left the output register
    assign out_load  = (r_state == ST_ADD) && r_last && (!r_out_valid || i_ready);
    assign o_valid   = r_out_valid;
    assign o_digest  = r_out;

    // single byte write port into the block buffer
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = pos;
        wr_byte = i_q_item.data_byte;
        if (take && i_q_item.has_byte) begin
            wr_en = 1'b1;
        end else if (r_state == ST_PAD) begin
            wr_en  = 1'b1;
            wr_idx = r_ppos;
            if (r_mark)
                wr_byte = PAD_BYTE;
            else if (r_last && r_ppos >= 6'(LEN_OFFSET))
                wr_byte = len_byte;
            else
                wr_byte = 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    if (i_q_item.has_byte && pos == 6'd63) n_state = ST_RUN;
                    else if (i_q_item.end_of_message)      n_state = ST_PAD;
                end
            end
            ST_PAD:  if (r_ppos == 6'd63) n_state = ST_RUN;
            ST_RUN:  if (r_rnd == 6'd63) n_state = ST_ADD;
            ST_ADD: begin
                if (r_last) begin
                    if (out_load) n_state = ST_IDLE;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_w[wr_idx[5:2]][{wr_idx[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bits      <= '0;
            r_len       <= '0;
            r_h[0]      <= H0_INIT;
            r_h[1]      <= H1_INIT;
            r_h[2]      <= H2_INIT;
            r_h[3]      <= H3_INIT;
            r_a         <= '0;
            r_b         <= '0;
            r_c         <= '0;
            r_d         <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            r_rnd       <= '0;
            r_ppos      <= '0;
            r_fin       <= 1'b0;
            r_mark      <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && !i_ready);
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        if (i_q_item.has_byte) r_bits <= r_bits + 64'd8;
                        r_len  <= r_bits + (i_q_item.has_byte ? 64'd8 : 64'd0);
                        r_ppos <= i_q_item.has_byte ? pos + 6'd1 : pos;
                        r_fin  <= i_q_item.end_of_message;
                        r_mark <= i_q_item.end_of_message;
                        r_last <= 1'b0;
                        r_rnd  <= '0;
                        r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                    end
                end
                ST_PAD: begin
                    r_ppos <= r_ppos + 6'd1;
                    if (r_mark) begin
                        // length fits behind the mark only below offset 56
                        r_mark <= 1'b0;
                        r_last <= (r_ppos < 6'(LEN_OFFSET));
                    end
                end
                ST_RUN: begin
                    r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= t;
                    r_rnd <= r_rnd + 6'd1;
                end
                ST_ADD: begin
                    if (r_last) begin
                        if (out_load) begin
                            r_out.first_half  <= {r_h[1] + r_b, r_h[0] + r_a};
                            r_out.second_half <= {r_h[3] + r_d, r_h[2] + r_c};
                            r_h[0] <= H0_INIT; r_h[1] <= H1_INIT;
                            r_h[2] <= H2_INIT; r_h[3] <= H3_INIT;
                            r_bits <= '0;
                            r_fin  <= 1'b0;
                        end
                    end else begin
                        r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                        r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                        r_a <= r_h[0] + r_a; r_b <= r_h[1] + r_b;
                        r_c <= r_h[2] + r_c; r_d <= r_h[3] + r_d;
                        // end pending: next block starts padding at byte 0
                        r_ppos <= '0;
                        r_last <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: design/md5_byte_stream_hasher.sv
// bytes pass the front queue to the block buffer, one per cycle while the back is idle
// a full block holds the back for 64 rounds plus chaining add; a full queue stalls input
// end of message: up to 64 padding bytes per padded block, 64 rounds plus chaining add for
// each of one or two compressions; the digest sits in an output register until transferred
// and a following digest waits in the back part while that register is full
// reset: synchronous active-low, restores initial chaining words and clears the count
module md5_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_has_byte,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_first_half,
    output logic [63:0] o_digest_second_half
);
    import md5_pkg::*;

    logic    q_valid, q_ready;
    t_item   q_item;
    t_digest digest;

    md5_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_has_byte, .i_data_byte, .i_end_of_message,
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_item(q_item)
    );

    md5_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_item(q_item),
        .o_valid, .i_ready, .o_digest(digest)
    );

    assign o_digest_first_half  = digest.first_half;
    assign o_digest_second_half = digest.second_half;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_first_half)
            && $stable(o_digest_second_half))
        else $error("digest changed while stalled");
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> q_valid)
        else $error("input stalled with an empty queue");
`endif

endmodule

// File: bench/tb_md5_byte_stream_hasher.sv
`timescale 1ns / 1ps

module tb_md5_byte_stream_hasher;
    import md5_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_has_byte;
    logic [7:0]  i_data_byte;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_digest_first_half;
    logic [63:0] o_digest_second_half;

    int mismatch_count = 0;
    int cycle_count = 0;
    bit hold_off = 0;

    md5_byte_stream_hasher dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_has_byte(i_has_byte),
        .i_data_byte(i_data_byte),
        .i_end_of_message(i_end_of_message),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_digest_first_half(o_digest_first_half),
        .o_digest_second_half(o_digest_second_half)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // md5 predictor with its own chaining words, block buffer and bit count
    class digest_scoreboard;
        logic [31:0] chain [4];
        logic [7:0]  blk [64];
        logic [63:0] nbits;
        t_digest     pending [$];

        function new();
            restart();
        endfunction

        function void restart();
            chain[0] = H0_INIT;
            chain[1] = H1_INIT;
            chain[2] = H2_INIT;
            chain[3] = H3_INIT;
            nbits = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function void fold_block();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, f, t;
            int g, r;
            int shifts [4][4] = '{'{7, 12, 17, 22}, '{5, 9, 14, 20},
                                  '{4, 11, 16, 23}, '{6, 10, 15, 21}};
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            for (int i = 0; i < 64; i++) begin
                r = i / 16;
                case (r)
                    0: begin f = (b & c) | (~b & d); g = i; end
                    1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                    2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                    default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
                endcase
                t = a + f + w[g] + ROUND_K[i];
                t = b + rol(t, shifts[r][i % 4]);
                a = d; d = c; c = b; b = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        endfunction

        function void note_transfer(logic has, logic [7:0] data, logic fin);
            int pos;
            logic [63:0] len;
            t_digest dg;
            if (has) begin
                pos = nbits[8:3];
                blk[pos] = data;
                nbits += 8;
                if (pos == 63) fold_block();
            end
            if (!fin) return;
            len = nbits;
            pos = nbits[8:3];
            blk[pos] = PAD_BYTE;
            pos++;
            if (pos > LEN_OFFSET) begin
                while (pos < BLOCK_BYTES) blk[pos++] = 8'h00;
                fold_block();
                pos = 0;
            end
            while (pos < LEN_OFFSET) blk[pos++] = 8'h00;
            for (int k = 0; k < 8; k++) blk[LEN_OFFSET + k] = len[8*k +: 8];
            fold_block();
            dg.first_half = {chain[1], chain[0]};
            dg.second_half = {chain[3], chain[2]};
            pending.push_back(dg);
            restart();
        endfunction

        task check_digest(logic [63:0] lo, logic [63:0] hi);
            t_digest dg;
            if (pending.size() == 0) begin
                report_mismatch("unexpected digest", lo, 64'h0);
                return;
            end
            dg = pending.pop_front();
            if (lo !== dg.first_half) report_mismatch("first half", lo, dg.first_half);
            if (hi !== dg.second_half) report_mismatch("second half", hi, dg.second_half);
        endtask
    endclass

    digest_scoreboard sb = new();

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_transfer(i_has_byte, i_data_byte, i_end_of_message);
        if (i_rst_n && o_valid && i_ready)
            sb.check_digest(o_digest_first_half, o_digest_second_half);
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        i_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 0;
                repeat (600) @(negedge i_clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                i_ready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1;
            @(posedge i_clk iff o_valid);
        end
    end

    bit sender_busy_gaps = 1;

    task automatic send_item(input logic has, input logic [7:0] data, input logic fin);
        int gap;
        gap = sender_busy_gaps ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1;
        i_has_byte <= has;
        i_data_byte <= data;
        i_end_of_message <= fin;
        @(posedge i_clk iff o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit end_carries_byte);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1 && end_carries_byte)
                send_item(1, 8'($urandom), 1);
            else
                send_item(1, 8'($urandom), 0);
            // occasional empty item inside the message
            if ($urandom_range(0, 19) == 0) send_item(0, 8'($urandom), 0);
        end
        if (!end_carries_byte || len == 0) send_item(0, 8'($urandom), 1);
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int total;
        int len;
        i_clk = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_has_byte = 0;
        i_data_byte = 0;
        i_end_of_message = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty message, "abc", extremes of byte values, noise
        send_item(0, 8'hff, 0);
        send_item(0, 8'h00, 1);
        send_item(1, 8'h61, 0);
        send_item(1, 8'h62, 0);
        send_item(1, 8'h63, 1);
        send_item(1, 8'h00, 0);
        send_item(1, 8'hff, 1);
        send_item(0, 8'h5a, 0);
        send_item(1, 8'haa, 0);
        send_item(1, 8'h55, 0);
        send_item(0, 8'h00, 1);
        wait_drained();

        // padding boundaries: 55, 56, 63, 64 byte messages
        send_message(55, 1);
        send_message(56, 0);
        send_message(63, 1);
        send_message(64, 1);
        wait_drained();

        // back pressure: receiver stalls while sender streams without gaps
        hold_off = 1;
        sender_busy_gaps = 0;
        for (int m = 0; m < 6; m++) send_message($urandom_range(0, 8), 1);
        sender_busy_gaps = 1;
        wait_drained();

        total = 0;
        while (total < 1100) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(120, 130);
                1, 2: len = $urandom_range(50, 70);
                default: len = $urandom_range(0, 20);
            endcase
            send_message(len, $urandom_range(0, 1));
            total += len + 1;
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        wait_drained();
        repeat (300) @(negedge i_clk);

        if (mismatch_count == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
